// ===== hdl/s2i_pkg.sv =====
// Shared types, constants and helper functions for the string-to-integer parser.
// Used by s2i_step, the top level and the assertion checker.
package s2i_pkg;

    localparam int OFFSET_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;
    localparam int VALUE_BITS     = 64;
    localparam int END_BITS       = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX         = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNSIGNED_MODE = 2'd1;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] BASE_AUTO   = 6'd0;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_MAX    = 6'd36;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [VALUE_BITS-1:0] LIM_UNSIGNED = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] LIM_NEG      = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] LIM_POS      = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct packed {
        logic [2:0]             phase;
        logic [VALUE_BITS-1:0]  acc;
        logic                   negative;
        logic [5:0]             base;
        logic [OFFSET_BITS-1:0] position;
        logic [OFFSET_BITS-1:0] last_end;
        logic                   any_digit;
        logic                   overflowed;
    } parse_state_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [END_BITS-1:0]   end_offset;
        logic                  converted;
        logic                  range_error;
    } parse_result_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:      PH_SPACE,
        acc:        '0,
        negative:   1'b0,
        base:       '0,
        position:   '0,
        last_end:   '0,
        any_digit:  1'b0,
        overflowed: 1'b0
    };

    // Returns {valid, digit}. A digit is valid when it is below the base and the base
    // is at most 36.
    function automatic logic [6:0] digit_of(input logic [7:0] c, input logic [5:0] base);
        logic [7:0] raw;
        logic       is_alnum;
        raw      = 8'd0;
        is_alnum = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            raw = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            raw = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            raw = c - CH_UA + 8'd10;
        end else begin
            is_alnum = 1'b0;
        end
        return {is_alnum && (base <= BASE_MAX) && (raw[5:0] < base), raw[5:0]};
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== hdl/string_to_int64_parser_top.sv =====
// Streaming string-to-integer parser, top level: handshake, configuration and state.
// Depends on s2i_pkg and s2i_step.
//
// Usage:
//   The input channel (s_valid, s_ready, s_ch) carries one byte of a NUL-terminated
//   string per transfer. Leading white space, an optional sign and, depending on the
//   radix, a 0x prefix are taken, then digits below the base are accumulated.
//   The NUL byte closes the string: it produces one transfer on the result channel
//   (m_valid, m_ready, m_value, m_end_offset, m_converted, m_range_error) and the
//   parser rearms for the next string. Other bytes produce no result.
//   Configuration is a plain write port: cfg_we with cfg_index 0 writes the radix
//   (0 selects automatic decimal, octal or hex), cfg_index 1 writes the unsigned mode.
//   The user must write only while no string is in flight; the block does not enforce it.
// Timing:
//   Every byte is handled in the cycle it is transferred; one byte per clock is
//   sustained while no result is stalled. The result of a NUL byte shows on the
//   result port the cycle after its transfer, from the output register. Each step
//   is one 64 by 6 bit multiply, an add and a compare against the saturation limit.
// Stall and reset:
//   While a result waits in the output register and m_ready is low, s_ready is low;
//   when m_ready is high a new byte is taken in the same cycle the result leaves.
//   A synchronous low on aresetn clears the parse state and the output valid flag and
//   restores radix 10 in signed mode.
module string_to_int64_parser_top
    import s2i_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_ch,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [VALUE_BITS-1:0]     m_value,
    output logic [END_BITS-1:0]       m_end_offset,
    output logic                      m_converted,
    output logic                      m_range_error,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    logic [5:0]    radix_reg;
    logic          umode_reg;
    parse_state_t  st_reg;
    parse_state_t  st_next;
    parse_result_t res_next;
    parse_result_t res_reg;
    logic          m_valid_reg;
    logic          s_xfer;
    logic          nul_xfer;

    s2i_step u_step (
        .st            (st_reg),
        .ch            (s_ch),
        .radix         (radix_reg),
        .unsigned_mode (umode_reg),
        .st_next       (st_next),
        .res           (res_next)
    );

    // The output register frees in the same cycle its result is taken.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_xfer   = s_valid && s_ready;
    assign nul_xfer = s_xfer && (s_ch == CH_NUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            umode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RADIX:         radix_reg <= cfg_wdata;
                REG_UNSIGNED_MODE: umode_reg <= cfg_wdata[0];
                default:           radix_reg <= radix_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= PARSE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                st_reg <= st_next;
            end
            if (nul_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (nul_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value       = res_reg.value;
    assign m_end_offset  = res_reg.end_offset;
    assign m_converted   = res_reg.converted;
    assign m_range_error = res_reg.range_error;

endmodule

// ===== hdl/s2i_step.sv =====
// Next-state and result logic of the parser for one accepted character.
// Depends on s2i_pkg; purely combinational.
module s2i_step
    import s2i_pkg::*;
(
    input  parse_state_t  st,
    input  logic [7:0]    ch,
    input  logic [5:0]    radix,
    input  logic          unsigned_mode,
    output parse_state_t  st_next,
    output parse_result_t res
);

    logic                   starting;
    logic                   auto_or_hex;
    logic [5:0]             take_base;
    logic [6:0]             dig;
    logic                   d_valid;
    logic [5:0]             d_val;
    logic [VALUE_BITS-1:0]  limit;
    logic [69:0]            prod;
    logic [70:0]            sum;
    logic                   ovf_now;
    logic [OFFSET_BITS-1:0] next_off;
    logic [31:0]            end_wide;

    assign starting    = (st.phase == PH_SPACE) || (st.phase == PH_START);
    assign auto_or_hex = (radix == BASE_AUTO) || (radix == BASE_HEX);

    // At the first character of the number the base comes from the radix register.
    assign take_base = starting ? ((radix == BASE_AUTO) ? BASE_DEC : radix) : st.base;

    assign dig     = digit_of(ch, take_base);
    assign d_valid = dig[6];
    assign d_val   = dig[5:0];

    always_comb begin
        if (unsigned_mode) begin
            limit = LIM_UNSIGNED;
        end else if (st.negative) begin
            limit = LIM_NEG;
        end else begin
            limit = LIM_POS;
        end
    end

    // acc * base + d > limit is the same test as acc > (limit - d) / base.
    assign prod    = 70'(st.acc) * 70'(take_base);
    assign sum     = 71'(prod) + 71'(d_val);
    assign ovf_now = sum > 71'(limit);

    assign next_off = (st.position == OFFSET_MAX) ? OFFSET_MAX : st.position + 1'b1;

    always_comb begin
        st_next = st;
        if (ch == CH_NUL) begin
            st_next = PARSE_CLEAR;
        end else begin
            case (st.phase)
                PH_SPACE, PH_START: begin
                    if (st.phase == PH_SPACE && is_white(ch)) begin
                        st_next.phase = PH_SPACE;
                    end else if (st.phase == PH_SPACE && ch == CH_PLUS) begin
                        st_next.phase = PH_START;
                    end else if (st.phase == PH_SPACE && ch == CH_MINUS) begin
                        st_next.negative = 1'b1;
                        st_next.phase    = PH_START;
                    end else if (auto_or_hex && ch == CH_ZERO) begin
                        st_next.base      = (radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                        st_next.acc       = '0;
                        st_next.any_digit = 1'b1;
                        st_next.last_end  = next_off;
                        st_next.phase     = PH_ZERO;
                    end else begin
                        st_next.base = take_base;
                        if (!d_valid) begin
                            st_next.phase = PH_DONE;
                        end else begin
                            st_next.phase     = PH_DIGITS;
                            st_next.any_digit = 1'b1;
                            st_next.last_end  = next_off;
                            if (!st.overflowed) begin
                                if (ovf_now) begin
                                    st_next.overflowed = 1'b1;
                                end else begin
                                    st_next.acc = sum[VALUE_BITS-1:0];
                                end
                            end
                        end
                    end
                end
                PH_ZERO, PH_DIGITS: begin
                    if (st.phase == PH_ZERO && (ch == CH_LX || ch == CH_UX)) begin
                        // The prefix does not move the end: a bare 0x ends after the 0.
                        st_next.base  = BASE_HEX;
                        st_next.phase = PH_DIGITS;
                    end else if (!d_valid) begin
                        st_next.phase = PH_DONE;
                    end else begin
                        st_next.phase     = PH_DIGITS;
                        st_next.any_digit = 1'b1;
                        st_next.last_end  = next_off;
                        if (!st.overflowed) begin
                            if (ovf_now) begin
                                st_next.overflowed = 1'b1;
                            end else begin
                                st_next.acc = sum[VALUE_BITS-1:0];
                            end
                        end
                    end
                end
                default: begin
                    st_next.phase = st.phase;
                end
            endcase
            st_next.position = next_off;
        end
    end

    assign end_wide = 32'(st.last_end);

    always_comb begin
        res = '0;
        if (st.any_digit) begin
            res.converted  = 1'b1;
            res.end_offset = end_wide[END_BITS-1:0];
            if (st.overflowed) begin
                res.range_error = 1'b1;
                if (unsigned_mode) begin
                    res.value = LIM_UNSIGNED;
                end else if (st.negative) begin
                    res.value = LIM_NEG;
                end else begin
                    res.value = LIM_POS;
                end
            end else begin
                res.value = st.negative ? ('0 - st.acc) : st.acc;
            end
        end
    end

endmodule

// ===== hdl/s2i_checker.sv =====
// Port-level assertions for the string-to-integer parser, bound to the top level.
// Depends on s2i_pkg and string_to_int64_parser_top.
module s2i_checker
    import s2i_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [7:0]            s_ch,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [VALUE_BITS-1:0] m_value,
    input logic [END_BITS-1:0]   m_end_offset,
    input logic                  m_converted,
    input logic                  m_range_error
);

    // A stalled result keeps its value and end offset.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_end_offset))
        else $error("stalled result changed");

    // A NUL transfer always delivers a result in the next cycle.
    a_nul_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_ch == CH_NUL |=> m_valid)
        else $error("NUL transfer without result");

    // No input is taken while a result is stalled.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // Without conversion every field reads zero, and a range error implies conversion.
    a_no_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_converted |->
            m_value == '0 && m_end_offset == '0 && !m_range_error)
        else $error("fields set without conversion");

endmodule

bind string_to_int64_parser_top s2i_checker u_s2i_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_ch          (s_ch),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value       (m_value),
    .m_end_offset  (m_end_offset),
    .m_converted   (m_converted),
    .m_range_error (m_range_error)
);
